>>> hw/rtl/gh_pkg.sv
// Shared constants, types and the base32 alphabet for the geohash encoder.
// No dependencies; used by geohash_encoder and gh_checker.
package gh_pkg;

    localparam int DEF_MAX_CHARS = 12;
    localparam int DEF_FRAC_BITS = 24;
    localparam int EXTRA_BITS    = 4;
    localparam int SYM_W         = 5;
    localparam int ASCII_W       = 7;
    localparam int IDX_W         = 4;
    localparam int PREC_W        = 4;
    localparam logic [PREC_W-1:0] PREC_RESET = 4'd12;

    typedef logic [SYM_W-1:0]   t_symbol;
    typedef logic [ASCII_W-1:0] t_ascii;

    function automatic t_ascii ascii_of(input t_symbol s);
        t_ascii a;
        case (s)
            5'd0:    a = 7'h30;
            5'd1:    a = 7'h31;
            5'd2:    a = 7'h32;
            5'd3:    a = 7'h33;
            5'd4:    a = 7'h34;
            5'd5:    a = 7'h35;
            5'd6:    a = 7'h36;
            5'd7:    a = 7'h37;
            5'd8:    a = 7'h38;
            5'd9:    a = 7'h39;
            5'd10:   a = 7'h62;
            5'd11:   a = 7'h63;
            5'd12:   a = 7'h64;
            5'd13:   a = 7'h65;
            5'd14:   a = 7'h66;
            5'd15:   a = 7'h67;
            5'd16:   a = 7'h68;
            5'd17:   a = 7'h6a;
            5'd18:   a = 7'h6b;
            5'd19:   a = 7'h6d;
            5'd20:   a = 7'h6e;
            5'd21:   a = 7'h70;
            5'd22:   a = 7'h71;
            5'd23:   a = 7'h72;
            5'd24:   a = 7'h73;
            5'd25:   a = 7'h74;
            5'd26:   a = 7'h75;
            5'd27:   a = 7'h76;
            5'd28:   a = 7'h77;
            5'd29:   a = 7'h78;
            5'd30:   a = 7'h79;
            5'd31:   a = 7'h7a;
            default: a = 7'h30;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/geohash_encoder.sv
// Geohash encoder: latitude/longitude pair in, one base32 character per output word.
// Depends on gh_pkg for constants and the alphabet lookup.
// The input is registered in stage 0, then passes the bisection stages and the output
// register, all held while o_stall is high; each bisection stage does one longitude
// and one latitude step. One word per cycle while i_stall is low; a pair has 1 to 12 chars.
// Reset clears all valid bits and sets the precision register r_prec to 12.
module geohash_encoder #(
    parameter int MAX_CHARS = gh_pkg::DEF_MAX_CHARS,
    parameter int FRAC_BITS = gh_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [gh_pkg::PREC_W-1:0]         i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [31:0]                i_latitude,
    input  logic signed [32:0]                i_longitude,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gh_pkg::SYM_W-1:0]          o_symbol,
    output logic [gh_pkg::ASCII_W-1:0]        o_ascii_char,
    output logic [gh_pkg::IDX_W-1:0]          o_char_index,
    output logic                              o_last_char
);

    localparam int NB    = MAX_CHARS * gh_pkg::SYM_W;
    localparam int NS    = (NB + 1) / 2;
    localparam int SCALE = FRAC_BITS + gh_pkg::EXTRA_BITS;
    localparam int CW    = (FRAC_BITS + 14 > 38) ? FRAC_BITS + 14 : 38;
    localparam logic [CW-1:0] LAT_SPAN = CW'(64'd180 << SCALE);
    localparam logic [CW-1:0] LNG_SPAN = CW'(64'd360 << SCALE);
    localparam logic [CW-1:0] LAT_HALF = LAT_SPAN >> 1;
    localparam logic [CW-1:0] LNG_HALF = LNG_SPAN >> 1;

    logic [gh_pkg::PREC_W-1:0] r_prec;
    logic [gh_pkg::IDX_W-1:0]  w_cnt;
    logic                      w_en;
    logic                      w_out_acc;
    logic                      w_last;

    logic [NS:0]              r_v;
    logic signed [CW-1:0]     r_lat_r [0:NS];
    logic [CW-1:0]            r_lat_w [0:NS];
    logic signed [CW-1:0]     r_lng_r [0:NS];
    logic [CW-1:0]            r_lng_w [0:NS];
    logic [NB-1:0]            r_code  [0:NS];

    logic                      r_ev;
    logic [NB-1:0]             r_ecode;
    logic [gh_pkg::IDX_W-1:0]  r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= gh_pkg::PREC_RESET;
        end else if (i_cfg_wr_en) begin
            r_prec <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_prec == '0) begin
            w_cnt = gh_pkg::IDX_W'(1);
        end else if (r_prec > gh_pkg::PREC_W'(MAX_CHARS)) begin
            w_cnt = gh_pkg::IDX_W'(MAX_CHARS);
        end else begin
            w_cnt = r_prec;
        end
    end

    assign w_out_acc = r_ev && !i_stall;
    assign w_last    = (r_idx == w_cnt - gh_pkg::IDX_W'(1));
    assign w_en      = !r_ev || (w_out_acc && w_last);
    assign o_stall   = !w_en;

    // Stage 0 offsets both coordinates so that the intervals start at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat_r[0] <= (CW'(i_latitude) << gh_pkg::EXTRA_BITS) + LAT_HALF;
            r_lng_r[0] <= (CW'(i_longitude) << gh_pkg::EXTRA_BITS) + LNG_HALF;
            r_lat_w[0] <= LAT_SPAN;
            r_lng_w[0] <= LNG_SPAN;
            r_code[0]  <= '0;
        end
    end

    // Each stage keeps the coordinate relative to the lower bound and the interval width.
    // The midpoint offset is the floor of half the width.
    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int LAT_POS = (2 * j + 1 < NB) ? NB - 2 - 2 * j : 0;

        logic [CW-1:0] w_lng_h;
        logic [CW-1:0] w_lat_h;
        logic          w_lng_b;
        logic          w_lat_b;
        logic [NB-1:0] n_code;

        assign w_lng_h = r_lng_w[j] >> 1;
        assign w_lat_h = r_lat_w[j] >> 1;
        assign w_lng_b = (r_lng_r[j] >= $signed(w_lng_h));
        assign w_lat_b = (r_lat_r[j] >= $signed(w_lat_h));

        always_comb begin
            n_code = r_code[j];
            n_code[NB-1-2*j] = w_lng_b;
            if (2 * j + 1 < NB) begin
                n_code[LAT_POS] = w_lat_b;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lng_r[j+1] <= w_lng_b ? r_lng_r[j] - $signed(w_lng_h) : r_lng_r[j];
                r_lng_w[j+1] <= w_lng_b ? r_lng_w[j] - w_lng_h : w_lng_h;
                r_lat_r[j+1] <= w_lat_b ? r_lat_r[j] - $signed(w_lat_h) : r_lat_r[j];
                r_lat_w[j+1] <= w_lat_b ? r_lat_w[j] - w_lat_h : w_lat_h;
                r_code[j+1]  <= n_code;
            end
        end
    end

    // The output register holds the finished code and shifts out one character per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev  <= 1'b0;
            r_idx <= '0;
        end else if (w_en) begin
            r_ev  <= r_v[NS];
            r_idx <= '0;
        end else if (w_out_acc) begin
            r_idx <= r_idx + gh_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ecode <= r_code[NS];
        end else if (w_out_acc) begin
            r_ecode <= r_ecode << gh_pkg::SYM_W;
        end
    end

    assign o_valid      = r_ev;
    assign o_symbol     = r_ecode[NB-1 -: gh_pkg::SYM_W];
    assign o_ascii_char = gh_pkg::ascii_of(r_ecode[NB-1 -: gh_pkg::SYM_W]);
    assign o_char_index = r_idx;
    assign o_last_char  = w_last;

endmodule

>>> hw/rtl/gh_checker.sv
// Port-level checks for geohash_encoder, attached with a bind statement.
// Depends on gh_pkg for widths and the alphabet lookup.
module gh_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [gh_pkg::SYM_W-1:0]     o_symbol,
    input logic [gh_pkg::ASCII_W-1:0]   o_ascii_char,
    input logic [gh_pkg::IDX_W-1:0]     o_char_index,
    input logic                         o_last_char
);

    // A stalled output word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_char_index)
        && $stable(o_last_char))
        else $error("output word changed while stalled");

    // Characters of one pair follow each other without gaps in the index.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_char |=>
        o_valid && o_char_index == $past(o_char_index) + 4'd1)
        else $error("character index did not advance");

    // A new pair always starts at index zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_char |=> !o_valid || o_char_index == 4'd0)
        else $error("new pair did not start at index zero");

    // The ASCII code matches the symbol.
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ascii_char == gh_pkg::ascii_of(o_symbol))
        else $error("ascii code does not match symbol");

endmodule

bind geohash_encoder gh_checker u_gh_checker (.*);
